// File: rtl/gidq_pkg.sv
package gidq_pkg;

    localparam int Lanes = 8;

    // Input packing, highest bit first.
    typedef struct packed {
        logic [63:0] scales_4_7;
        logic [63:0] scales_0_3;
        logic [31:0] zero_word;
        logic [63:0] weight_words_6_7;
        logic [63:0] weight_words_4_5;
        logic [63:0] weight_words_2_3;
        logic [63:0] weight_words_0_1;
        logic [2:0]  row_nibble;
    } in_beat_t;

    localparam int InBits  = $bits(in_beat_t);
    localparam int InBytes = (InBits + 7) / 8;

    // Stage-1 lane result passed to the rounding stage.
    typedef struct packed {
        logic        special;   // result fully known (NaN, inf, zero)
        logic [15:0] special_val;
        logic        sgn;
        logic [14:0] prod;      // mantissa times |d|, up to 2047*16
        logic        sub;       // subnormal scale
        logic [4:0]  ex;
    } lane_mid_t;

endpackage

// File: rtl/gptq_int4_dequant_fp16_core.sv
// GPTQ int4 -> fp16 dequantizer. Each input beat carries one weight row for
// eight output columns; eight lanes each compute (q - (z+1)) * scale exactly
// and round once to fp16 (nearest-even, gradual underflow, overflow to inf,
// NaN quieted). One beat per cycle sustained unless m_axis_tready stalls;
// an accepted beat passes the multiply stage, the round stage and the output
// register. The pipeline advances whenever the output register is free or
// being drained, so s_axis_tready drops whenever a valid output beat is
// held off by m_axis_tready, even if earlier stages hold bubbles.
module gptq_int4_dequant_fp16_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // row_nibble[2:0], weight_words_0_1, _2_3, _4_5, _6_7, zero_word,
    // scales_0_3, scales_4_7; zero-padded to bytes
    input  logic [gidq_pkg::InBytes*8-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // weights_0_3[63:0], weights_4_7[127:64]
    output logic [127:0] m_axis_tdata
);

    gidq_pkg::in_beat_t beat;
    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic       adv;

    assign beat = s_axis_tdata[gidq_pkg::InBits-1:0];

    // Whole pipe moves together; a bubble-free stall when output is blocked.
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[2];

    always_comb begin
        vld_next = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 3'd0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    logic [gidq_pkg::Lanes-1:0][31:0] words;
    logic [gidq_pkg::Lanes-1:0][15:0] scales;
    logic [gidq_pkg::Lanes-1:0][15:0] lane_res;

    assign words  = {beat.weight_words_6_7, beat.weight_words_4_5,
                     beat.weight_words_2_3, beat.weight_words_0_1};
    assign scales = {beat.scales_4_7, beat.scales_0_3};

    for (genvar j = 0; j < gidq_pkg::Lanes; j++) begin : g_lane
        logic [3:0] q;
        assign q = 4'(words[j] >> {beat.row_nibble, 2'b00});
        gidq_lane u_lane (
            .aclk   (aclk),
            .en     (adv),
            .q      (q),
            .z      (beat.zero_word[4*j +: 4]),
            .scale  (scales[j]),
            .result (lane_res[j])
        );
    end

    gidq_merge u_merge (
        .aclk     (aclk),
        .en       (adv),
        .lane_res (lane_res),
        .tdata    (m_axis_tdata)
    );

endmodule

// File: rtl/gidq_lane.sv
// One lane: exact fp16 x small integer, rounded to fp16 nearest-even.
// Stage 1 multiplies, stage 2 normalizes and rounds.
module gidq_lane (
    input  logic        aclk,
    input  logic        en,
    input  logic [3:0]  q,
    input  logic [3:0]  z,
    input  logic [15:0] scale,
    output logic [15:0] result
);

    gidq_pkg::lane_mid_t mid_reg;
    gidq_pkg::lane_mid_t mid_next;

    logic [5:0]  d;       // signed, -16..14
    logic [4:0]  mag;
    logic        dneg;
    logic [10:0] m;
    logic        ex_max;

    always_comb begin
        d        = {2'b00, q} - {2'b00, z} - 6'd1;
        dneg     = d[5];
        mag      = dneg ? 5'(-d) : d[4:0];
        ex_max   = (scale[14:10] == 5'h1F);
        m        = (scale[14:10] == 5'd0) ? {1'b0, scale[9:0]} : {1'b1, scale[9:0]};
        mid_next.sgn  = scale[15] ^ dneg;
        mid_next.prod = 15'(m * mag);
        mid_next.sub  = (scale[14:10] == 5'd0);
        mid_next.ex   = scale[14:10];
        mid_next.special     = 1'b0;
        mid_next.special_val = 16'h0000;
        if (ex_max && scale[9:0] != 10'd0) begin
            mid_next.special     = 1'b1;
            mid_next.special_val = scale | 16'h0200;
        end else if (ex_max) begin
            mid_next.special     = 1'b1;
            mid_next.special_val = (mag == 5'd0) ? 16'h7E00
                                                 : {scale[15] ^ dneg, 15'h7C00};
        end else if (mid_next.prod == 15'd0) begin
            mid_next.special     = 1'b1;
            mid_next.special_val = {scale[15] ^ dneg, 15'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg <= mid_next;
        end
    end

    // Stage 2. Work with biased exponents: e_field = ex (or 1 if subnormal),
    // value = prod * 2^(e_field - 25). msb of prod at bit msb; target
    // field f = msb + e_field - 10, clamped to >= 1 (subnormal floor).
    logic [3:0]  msb;
    logic [6:0]  t;        // msb + e_field, 1..45
    logic [6:0]  f;        // result field before carry
    logic signed [7:0] shift; // f - e_field
    logic [15:0] res;
    logic [14:0] rem;
    logic [14:0] half;
    logic [4:0]  efield;
    logic [6:0]  fout;
    logic [15:0] result_reg;
    logic [15:0] result_next;
    logic [3:0]  sh;

    always_comb begin
        msb = 4'd0;
        for (int i = 0; i < 15; i++) begin
            if (mid_reg.prod[i]) begin
                msb = 4'(i);
            end
        end
        efield = mid_reg.sub ? 5'd1 : mid_reg.ex;
        t      = 7'(msb) + 7'(efield);
        f      = (t > 7'd11) ? (t - 7'd10) : 7'd1;
        shift  = $signed({1'b0, f}) - $signed({3'b000, efield});
        res    = 16'd0;
        rem    = 15'd0;
        half   = 15'd0;
        sh     = 4'd0;
        if (shift <= 0) begin
            sh  = 4'(-shift);
            res = 16'({1'b0, mid_reg.prod} << sh);
        end else begin
            sh   = 4'(shift);
            res  = 16'(mid_reg.prod >> sh);
            rem  = mid_reg.prod & 15'((16'd1 << sh) - 16'd1);
            half = 15'(16'd1 << (sh - 4'd1));
            if (rem > half || (rem == half && res[0])) begin
                res = res + 16'd1;
            end
        end
        fout = f;
        if (res >= 16'h0800) begin
            res  = res >> 1;
            fout = f + 7'd1;
        end
        // res < 0x400 only when fout == 1 (subnormal): field-1 = 0 then.
        if (mid_reg.special) begin
            result_next = mid_reg.special_val;
        end else if (fout >= 7'd31) begin
            result_next = {mid_reg.sgn, 15'h7C00};
        end else begin
            result_next = {mid_reg.sgn, 15'(({8'd0, fout} - 15'd1) << 10) + 15'(res)};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/gidq_merge.sv
// Packs the eight lane results into the output beat register.
module gidq_merge (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [gidq_pkg::Lanes-1:0][15:0]   lane_res,
    output logic [127:0]                       tdata
);

    logic [127:0] data_reg;
    logic [127:0] data_next;

    always_comb begin
        data_next = lane_res;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign tdata = data_reg;

endmodule

// File: rtl/gidq_checker.sv
// Port-level checks for the dequantizer.
module gidq_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat did not appear after three cycles");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind gptq_int4_dequant_fp16_core gidq_checker u_gidq_checker (.*);
